// ===== rtl/symbol_dictionary_coder_core_macros.svh =====
// Assertion macros for the symbol dictionary coder checker.
`ifndef SYMBOL_DICTIONARY_CODER_CORE_MACROS_SVH
`define SYMBOL_DICTIONARY_CODER_CORE_MACROS_SVH

// Check on every clock edge outside reset.
`define SDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define SDC_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sdc_pkg.sv =====
// Shared types and constants of the symbol dictionary coder.
package sdc_pkg;

    localparam logic [1:0] OP_LEARN  = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_DECODE = 2'd2;

    localparam logic [1:0] STAT_FOUND = 2'd0;
    localparam logic [1:0] STAT_NEW   = 2'd1;
    localparam logic [1:0] STAT_MISS  = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE_RD,
        S_PROBE_CODE,
        S_PROBE_SYM,
        S_DECODE,
        S_RESP
    } state_t;

endpackage

// ===== rtl/sdc_if.sv =====
// Request and response channel interfaces of the symbol dictionary coder.
interface sdc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [31:0] value;
    logic               end_of_sequence;

    modport source (output valid, output operation, output value, output end_of_sequence,
                    input ready);
    modport sink   (input valid, input operation, input value, input end_of_sequence,
                    output ready);
endinterface

interface sdc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value_res;
    logic [1:0]         status;
    logic [10:0]        entries_used;
    logic               end_of_sequence_res;

    modport source (output valid, output value_res, output status, output entries_used,
                    output end_of_sequence_res, input ready);
    modport sink   (input valid, input value_res, input status, input entries_used,
                    input end_of_sequence_res, output ready);
endinterface

// ===== rtl/sdc_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
module sdc_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/sdc_ctrl.sv =====
// Probe sequencer, insert logic and output register of the symbol dictionary coder.
module sdc_ctrl import sdc_pkg::*; #(
    parameter int CAPACITY = 1024,
    parameter int CW       = $clog2(CAPACITY),
    parameter int CNTW     = $clog2(CAPACITY + 1),
    parameter int SW       = $clog2(CAPACITY) + 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        in_operation,
    input  logic [31:0]       in_value,
    input  logic              in_eos,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       out_value,
    output logic [1:0]        out_status,
    output logic [10:0]       out_used,
    output logic              out_eos,
    output logic              h_rd_en,
    output logic [SW-1:0]     h_rd_addr,
    input  logic [CW-1:0]     h_rd_data,
    output logic              h_wr_en,
    output logic [SW-1:0]     h_wr_addr,
    output logic [CW-1:0]     h_wr_data,
    output logic              s_rd_en,
    output logic [CW-1:0]     s_rd_addr,
    input  logic [SW+31:0]    s_rd_data,
    output logic              s_wr_en,
    output logic [CW-1:0]     s_wr_addr,
    output logic [SW+31:0]    s_wr_data
);

    state_t            state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic [31:0]       val_reg, val_next;
    logic              eos_reg, eos_next;
    logic [SW-1:0]     slot_reg, slot_next;
    logic [CW-1:0]     code_reg, code_next;
    logic [CNTW-1:0]   count_reg, count_next;
    logic [31:0]       res_value_reg, res_value_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_value_reg, out_value_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic [10:0]       out_used_reg, out_used_next;
    logic              out_eos_reg, out_eos_next;
    logic [31:0]       hash_prod;

    assign hash_prod = in_value * HASH_MULT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        val_reg        <= val_next;
        eos_reg        <= eos_next;
        slot_reg       <= slot_next;
        code_reg       <= code_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_used_reg   <= out_used_next;
        out_eos_reg    <= out_eos_next;
    end

    always_comb
    begin
        logic miss;
        miss            = 1'b0;
        state_next      = state_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        eos_next        = eos_reg;
        slot_next       = slot_reg;
        code_next       = code_reg;
        count_next      = count_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_used_next   = out_used_reg;
        out_eos_next    = out_eos_reg;
        in_ready        = 1'b0;
        h_rd_en         = 1'b0;
        h_rd_addr       = slot_reg;
        h_wr_en         = 1'b0;
        h_wr_addr       = slot_reg;
        h_wr_data       = count_reg[CW-1:0];
        s_rd_en         = 1'b0;
        s_rd_addr       = code_reg;
        s_wr_en         = 1'b0;
        s_wr_addr       = count_reg[CW-1:0];
        s_wr_data       = {val_reg, slot_reg};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next         = in_operation;
                    val_next        = in_value;
                    eos_next        = in_eos;
                    slot_next       = hash_prod[31 -: SW];
                    res_value_next  = in_value;
                    res_status_next = STAT_MISS;
                    case (in_operation)
                        OP_LEARN, OP_LOOKUP:
                        begin
                            state_next = S_PROBE_RD;
                        end
                        OP_DECODE:
                        begin
                            if (!in_value[31] && in_value < 32'(count_reg))
                            begin
                                s_rd_en    = 1'b1;
                                s_rd_addr  = in_value[CW-1:0];
                                state_next = S_DECODE;
                            end
                            else
                            begin
                                state_next = S_RESP;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_PROBE_RD:
            begin
                h_rd_en    = 1'b1;
                state_next = S_PROBE_CODE;
            end
            S_PROBE_CODE:
            begin
                code_next = h_rd_data;
                if (CNTW'(h_rd_data) < count_reg)
                begin
                    s_rd_en    = 1'b1;
                    s_rd_addr  = h_rd_data;
                    state_next = S_PROBE_SYM;
                end
                else
                begin
                    miss = 1'b1;
                end
            end
            S_PROBE_SYM:
            begin
                if (s_rd_data[SW-1:0] == slot_reg)
                begin
                    if (s_rd_data[SW+31:SW] == val_reg)
                    begin
                        res_value_next  = 32'(code_reg);
                        res_status_next = STAT_FOUND;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = S_PROBE_RD;
                    end
                end
                else
                begin
                    miss = 1'b1;
                end
            end
            S_DECODE:
            begin
                res_value_next  = s_rd_data[SW+31:SW];
                res_status_next = STAT_FOUND;
                state_next      = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                    out_used_next   = 11'(count_reg);
                    out_eos_next    = eos_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (miss)
        begin
            state_next = S_RESP;
            if (op_reg == OP_LEARN)
            begin
                if (count_reg < CNTW'(CAPACITY))
                begin
                    h_wr_en         = 1'b1;
                    s_wr_en         = 1'b1;
                    res_value_next  = 32'(count_reg);
                    res_status_next = STAT_NEW;
                    count_next      = count_reg + 1'b1;
                end
                else
                begin
                    res_status_next = STAT_FULL;
                end
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign out_used   = out_used_reg;
    assign out_eos    = out_eos_reg;

endmodule

// ===== rtl/symbol_dictionary_coder_core.sv =====
// Top level of the symbol dictionary coder: sequencer plus hash index and symbol store.
//
// Usage:
//   req carries operation, value and end_of_sequence; rsp returns value_res,
//   status, entries_used and end_of_sequence_res, one response per request.
//   Both channels transfer when valid and ready are high at a rising edge.
//   Encodes hash the symbol into an open-addressed index of 2**(clog2(CAPACITY)+1)
//   slots, probed linearly; each slot holds a code that is trusted only when it
//   is below the fill count and the store entry of that code points back at
//   the slot, so neither memory needs clearing.
//   A request is taken only in idle, so the next one waits until this response
//   is registered. An unused operation or an unassigned code goes straight to
//   the response and a decode reads the store once. An encode reads the index
//   slot, then, when its code is below the fill count, the store entry of that
//   code, and moves to the next slot when that entry points back with another symbol.
//   Reset clears the fill count, the sequencer and the output register;
//   memory contents are left as they are and no clearing pass runs.
//   While rsp is stalled one finished response is held and the next request
//   is still taken; its result then waits until the output register frees.
module symbol_dictionary_coder_core #(
    parameter int CAPACITY = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    sdc_in_if.sink     req,
    sdc_out_if.source  rsp
);

    localparam int CW   = $clog2(CAPACITY);
    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam int SW   = $clog2(CAPACITY) + 1;

    logic              h_rd_en;
    logic [SW-1:0]     h_rd_addr;
    logic [CW-1:0]     h_rd_data;
    logic              h_wr_en;
    logic [SW-1:0]     h_wr_addr;
    logic [CW-1:0]     h_wr_data;
    logic              s_rd_en;
    logic [CW-1:0]     s_rd_addr;
    logic [SW+31:0]    s_rd_data;
    logic              s_wr_en;
    logic [CW-1:0]     s_wr_addr;
    logic [SW+31:0]    s_wr_data;
    logic [31:0]       out_value;

    sdc_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW),
        .CNTW     (CNTW),
        .SW       (SW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (req.valid),
        .in_ready     (req.ready),
        .in_operation (req.operation),
        .in_value     ($unsigned(req.value)),
        .in_eos       (req.end_of_sequence),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .out_value    (out_value),
        .out_status   (rsp.status),
        .out_used     (rsp.entries_used),
        .out_eos      (rsp.end_of_sequence_res),
        .h_rd_en      (h_rd_en),
        .h_rd_addr    (h_rd_addr),
        .h_rd_data    (h_rd_data),
        .h_wr_en      (h_wr_en),
        .h_wr_addr    (h_wr_addr),
        .h_wr_data    (h_wr_data),
        .s_rd_en      (s_rd_en),
        .s_rd_addr    (s_rd_addr),
        .s_rd_data    (s_rd_data),
        .s_wr_en      (s_wr_en),
        .s_wr_addr    (s_wr_addr),
        .s_wr_data    (s_wr_data)
    );

    assign rsp.value_res = $signed(out_value);

    sdc_ram #(
        .DEPTH  (2 ** SW),
        .DATA_W (CW),
        .ADDR_W (SW)
    ) u_index (
        .clk     (clk),
        .rd_en   (h_rd_en),
        .rd_addr (h_rd_addr),
        .rd_data (h_rd_data),
        .wr_en   (h_wr_en),
        .wr_addr (h_wr_addr),
        .wr_data (h_wr_data)
    );

    sdc_ram #(
        .DEPTH  (CAPACITY),
        .DATA_W (SW + 32),
        .ADDR_W (CW)
    ) u_store (
        .clk     (clk),
        .rd_en   (s_rd_en),
        .rd_addr (s_rd_addr),
        .rd_data (s_rd_data),
        .wr_en   (s_wr_en),
        .wr_addr (s_wr_addr),
        .wr_data (s_wr_data)
    );

endmodule

// ===== rtl/sdc_checker.sv =====
// Port-level assertion checker of the symbol dictionary coder, with its bind.
`include "symbol_dictionary_coder_core_macros.svh"

module sdc_checker import sdc_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_value,
    input logic [1:0]  out_status,
    input logic [10:0] out_used
);

    logic [1:0] pending_reg, pending_next;

    always_comb
    begin
        pending_next = pending_reg;
        if ((in_valid && in_ready) && !(out_valid && out_ready))
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!(in_valid && in_ready) && (out_valid && out_ready))
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `SDC_ASSERT(a_rsp_hold, out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status), "response changed while stalled")
    `SDC_ASSERT(a_new_code, out_valid && out_status == STAT_NEW |-> out_value[10:0] == out_used - 11'd1, "new code does not match fill count")
    `SDC_ASSERT(a_no_orphan, out_valid |-> pending_reg != 2'd0, "response without an open request")
    `SDC_ASSERT(a_depth, pending_reg != 2'd3, "more than two requests open")
    `SDC_ASSERT_ANY(a_reset_idle, !rst_n |=> !out_valid, "response valid after reset")

endmodule

bind symbol_dictionary_coder_core sdc_checker u_sdc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_value (rsp.value_res),
    .out_status(rsp.status),
    .out_used  (rsp.entries_used)
);
